/* sv/assert_macros.svh */
// Assertion macros shared by the calculator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define HKC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("hkc assertion failed");
// condition must never be true outside reset
`define HKC_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("hkc forbidden condition seen");
`else
`define HKC_ASSERT(name, clk, rst_n, prop)
`define HKC_NEVER(name, clk, rst_n, cond)
`endif
`endif

/* sv/hkc_pkg.sv */
// Types and codes shared by the hex keypad calculator modules
package hkc_pkg;

	// width of the display port
	localparam int DISP_BITS = 32;

	// key classes
	typedef enum logic [1:0] {
		MODE_DIGIT = 2'd0,
		MODE_BKSP  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_OPER  = 2'd3
	} mode_t;

	// operator codes; 11 to 15 are stored but evaluate to zero
	typedef enum logic [3:0] {
		OP_EQ  = 4'd0,
		OP_ADD = 4'd1,
		OP_SUB = 4'd2,
		OP_MUL = 4'd3,
		OP_AND = 4'd4,
		OP_OR  = 4'd5,
		OP_XOR = 4'd6,
		OP_SHL = 4'd7,
		OP_SHR = 4'd8,
		OP_DIV = 4'd9,
		OP_MOD = 4'd10
	} op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FIN,
		ST_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_key;
		logic start_iter;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_iter;
		logic iter_last;
	} stat_t;

endpackage

/* sv/hkc_ctrl.sv */
// Controller state machine: request sequencing and datapath commands
module hkc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  hkc_pkg::stat_t stat,
	output hkc_pkg::cmd_t  cmd
);

	hkc_pkg::state_t state_q;
	hkc_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hkc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			hkc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (stat.need_iter) begin
						cmd.start_iter = 1'b1;
						state_d        = hkc_pkg::ST_CALC;
					end else begin
						cmd.load_key = 1'b1;
						state_d      = hkc_pkg::ST_OUT;
					end
				end
			end
			hkc_pkg::ST_CALC: begin
				cmd.step = 1'b1;
				if (stat.iter_last) begin
					state_d = hkc_pkg::ST_FIN;
				end
			end
			hkc_pkg::ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = hkc_pkg::ST_OUT;
			end
			hkc_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = hkc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hkc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/hkc_dp.sv */
// Datapath: calculator state, single-cycle ALU, shift-add multiplier and restoring divider
`include "assert_macros.svh"

module hkc_dp #(
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [1:0]                       mode,
	input  logic [3:0]                       digit_value,
	input  logic [3:0]                       operator_code,
	input  hkc_pkg::cmd_t                    cmd,
	output hkc_pkg::stat_t                   stat,
	output logic [hkc_pkg::DISP_BITS-1:0]    display_value,
	output logic                             beep
);

	localparam int SW = $clog2(WORD_BITS);
	localparam int CW = $clog2(WORD_BITS);

	// architectural state
	logic [WORD_BITS-1:0] entry_q;
	logic [WORD_BITS-1:0] first_q;
	logic [3:0]           pend_q;
	logic                 new_q;
	logic [hkc_pkg::DISP_BITS-1:0] display_q;
	logic                 beep_q;

	// iteration registers
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] sh_q;
	logic [WORD_BITS-1:0] b_q;
	logic [3:0]           op_q;
	logic [CW-1:0]        cnt_q;

	// key update
	logic [WORD_BITS-1:0] base;
	logic                 fits;
	logic [WORD_BITS-1:0] alu;
	logic                 big_shift;
	logic [WORD_BITS-1:0] key_entry;
	logic [WORD_BITS-1:0] key_first;
	logic [3:0]           key_pend;
	logic                 key_new;
	logic                 key_beep;

	// iteration step
	logic [WORD_BITS:0]   rsh;
	logic [WORD_BITS:0]   diff;
	logic [WORD_BITS-1:0] acc_n;
	logic [WORD_BITS-1:0] sh_n;
	logic [WORD_BITS-1:0] iter_res;

	// display is the low word of the zero-extended entry
	logic [WORD_BITS+hkc_pkg::DISP_BITS-1:0] key_ext;
	logic [WORD_BITS+hkc_pkg::DISP_BITS-1:0] iter_ext;

	// single-cycle operations of the pending operator
	always_comb begin
		big_shift = (entry_q >= WORD_BITS'(WORD_BITS));
		case (pend_q)
			hkc_pkg::OP_EQ:  alu = entry_q;
			hkc_pkg::OP_ADD: alu = first_q + entry_q;
			hkc_pkg::OP_SUB: alu = first_q - entry_q;
			hkc_pkg::OP_AND: alu = first_q & entry_q;
			hkc_pkg::OP_OR:  alu = first_q | entry_q;
			hkc_pkg::OP_XOR: alu = first_q ^ entry_q;
			hkc_pkg::OP_SHL: alu = big_shift ? '0 : (first_q << entry_q[SW-1:0]);
			hkc_pkg::OP_SHR: alu = big_shift ? '0 : (first_q >> entry_q[SW-1:0]);
			// multiply, divide and modulo go through the iterative unit
			default:         alu = '0;
		endcase
	end

	// next state for a key that needs no iteration
	always_comb begin
		base      = new_q ? '0 : entry_q;
		fits      = (base[WORD_BITS-1 -: 4] == 4'd0);
		key_entry = entry_q;
		key_first = first_q;
		key_pend  = pend_q;
		key_new   = new_q;
		key_beep  = 1'b0;
		case (mode)
			hkc_pkg::MODE_DIGIT: begin
				key_first = new_q ? entry_q : first_q;
				key_new   = 1'b0;
				key_entry = fits ? {base[WORD_BITS-5:0], digit_value} : base;
				key_beep  = !fits;
			end
			hkc_pkg::MODE_BKSP: begin
				key_entry = entry_q >> 4;
			end
			hkc_pkg::MODE_CLEAR: begin
				key_entry = '0;
			end
			hkc_pkg::MODE_OPER: begin
				key_entry = new_q ? entry_q : alu;
				key_new   = 1'b1;
				key_pend  = operator_code;
			end
			default: begin
				key_entry = entry_q;
			end
		endcase
	end

	// one multiply or divide bit per step, msb first
	always_comb begin
		rsh  = {acc_q, sh_q[WORD_BITS-1]};
		diff = rsh - {1'b0, b_q};
		if (op_q == hkc_pkg::OP_MUL) begin
			acc_n = {acc_q[WORD_BITS-2:0], 1'b0} + (sh_q[WORD_BITS-1] ? b_q : '0);
			sh_n  = {sh_q[WORD_BITS-2:0], 1'b0};
		end else if (!diff[WORD_BITS]) begin
			acc_n = diff[WORD_BITS-1:0];
			sh_n  = {sh_q[WORD_BITS-2:0], 1'b1};
		end else begin
			acc_n = rsh[WORD_BITS-1:0];
			sh_n  = {sh_q[WORD_BITS-2:0], 1'b0};
		end
	end

	// result of the iterative unit; a zero divisor gives all ones
	always_comb begin
		if (op_q == hkc_pkg::OP_MUL) begin
			iter_res = acc_q;
		end else if (b_q == '0) begin
			iter_res = '1;
		end else if (op_q == hkc_pkg::OP_DIV) begin
			iter_res = sh_q;
		end else begin
			iter_res = acc_q;
		end
	end

	assign key_ext  = {{hkc_pkg::DISP_BITS{1'b0}}, key_entry};
	assign iter_ext = {{hkc_pkg::DISP_BITS{1'b0}}, iter_res};

	// status to the controller
	assign stat.need_iter = (mode == hkc_pkg::MODE_OPER) && !new_q &&
		((pend_q == hkc_pkg::OP_MUL) || (pend_q == hkc_pkg::OP_DIV) ||
		 (pend_q == hkc_pkg::OP_MOD));
	assign stat.iter_last = (cnt_q == CW'(WORD_BITS - 1));

	// architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q   <= '0;
			first_q   <= '0;
			pend_q    <= hkc_pkg::OP_EQ;
			new_q     <= 1'b1;
			display_q <= '0;
			beep_q    <= 1'b0;
		end else if (cmd.load_key) begin
			entry_q   <= key_entry;
			first_q   <= key_first;
			pend_q    <= key_pend;
			new_q     <= key_new;
			display_q <= key_ext[hkc_pkg::DISP_BITS-1:0];
			beep_q    <= key_beep;
		end else if (cmd.start_iter) begin
			// operands are captured, so the new operator can be stored now
			pend_q <= operator_code;
			new_q  <= 1'b1;
		end else if (cmd.finish) begin
			entry_q   <= iter_res;
			display_q <= iter_ext[hkc_pkg::DISP_BITS-1:0];
			beep_q    <= 1'b0;
		end
	end

	// iterative unit registers
	always_ff @(posedge clk) begin
		if (cmd.start_iter) begin
			op_q  <= pend_q;
			sh_q  <= first_q;
			b_q   <= entry_q;
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.step) begin
			acc_q <= acc_n;
			sh_q  <= sh_n;
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign display_value = display_q;
	assign beep          = beep_q;

	`HKC_NEVER(a_cmd_onehot, clk, arst_n, !$onehot0({cmd.load_key, cmd.start_iter, cmd.step, cmd.finish}))
	`HKC_ASSERT(a_fin_sets_new, clk, arst_n, cmd.finish |=> new_q)
	`HKC_ASSERT(a_start_clears_cnt, clk, arst_n, cmd.start_iter |=> (cnt_q == '0))
	`HKC_ASSERT(a_beep_from_key, clk, arst_n, $rose(beep_q) |-> $past(cmd.load_key))

endmodule

/* sv/hex_keypad_calculator.sv */
// Hex keypad calculator top level: takes one key request per transaction and returns the
// entry value shown after it, with a beep flag for a digit dropped on overflow. Arithmetic
// is WORD_BITS wide; the display shows the low 32 bits, zero-extended when narrower. One key
// is in flight at a time: digit, backspace, clear and the add, subtract, logic and shift
// operators update the state directly from the request; an operator that applies a pending
// multiply, divide or modulo first runs the bit-serial unit for WORD_BITS steps, then a
// finish step. Divide or modulo by zero yields all ones.
module hex_keypad_calculator #(
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  digit_value,
	input  logic [3:0]  operator_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] display_value,
	output logic        beep
);

	hkc_pkg::cmd_t  cmd;
	hkc_pkg::stat_t stat;

	// request sequencing
	hkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// calculator state and arithmetic
	hkc_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode),
		.digit_value   (digit_value),
		.operator_code (operator_code),
		.cmd           (cmd),
		.stat          (stat),
		.display_value (display_value),
		.beep          (beep)
	);

endmodule
